// ===== design/prte_pkg.sv =====
`timescale 1ns / 1ps
package prte_pkg;
  localparam int RULES = 16;
  localparam int SENSORS = 8;
  localparam int CMDS = 4;
  localparam int RW = $clog2(RULES);

  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_CMD   = 2'd1,
    EV_DONE  = 2'd2
  } event_t;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_NE = 3'd1;
  localparam logic [2:0] OP_LT = 3'd2;
  localparam logic [2:0] OP_GT = 3'd3;
  localparam logic [2:0] OP_LE = 3'd4;
  localparam logic [2:0] OP_GE = 3'd5;
  localparam logic [2:0] OP_TRUE = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  rule_index;
    logic [7:0]  priority_req;
    logic [7:0]  state_mask;
    logic [2:0]  sensor_index;
    logic [2:0]  compare_op;
    logic signed [31:0] value;
    logic [31:0] dwell_ms;
    logic [2:0]  target_state;
    logic [2:0]  command_count;
    logic [15:0] command_codes;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] rule_number;
    logic [1:0] command_slot;
    logic [3:0] command_code;
    logic [2:0] machine_state;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [7:0]  mask;
    logic [2:0]  sensor;
    logic [2:0]  op;
    logic signed [31:0] threshold;
    logic [31:0] dwell;
    logic [2:0]  target;
    logic [2:0]  ncmd;
    logic [15:0] codes;
  } rule_t;

  // Result of evaluating one rule, passed from the evaluator to the sequencer.
  typedef struct packed {
    logic        hit;
    logic        start_we;
    logic [31:0] start_next;
  } eval_t;
endpackage

// ===== design/prte_eval.sv =====
`timescale 1ns / 1ps
module prte_eval (
  input  prte_pkg::rule_t     rule,
  input  logic signed [31:0]  reading,
  input  logic [31:0]         start,
  input  logic [31:0]         now_ms,
  input  logic [2:0]          cur_state,
  output prte_pkg::eval_t     res
);
  import prte_pkg::*;

  logic cond;
  logic enabled;
  logic [31:0] elapsed;

  // One shared compare unit: a signed comparison chosen by the code.
  always_comb begin
    unique case (rule.op)
      OP_EQ:   cond = (reading == rule.threshold);
      OP_NE:   cond = (reading != rule.threshold);
      OP_LT:   cond = (reading < rule.threshold);
      OP_GT:   cond = (reading > rule.threshold);
      OP_LE:   cond = (reading <= rule.threshold);
      OP_GE:   cond = (reading >= rule.threshold);
      default: cond = 1'b0;
    endcase
  end

  assign enabled = rule.mask[cur_state];
  assign elapsed = now_ms - start;

  always_comb begin
    res = '0;
    res.start_next = start;
    if (!enabled) begin
      res.hit = 1'b0;
    end else if (rule.op == OP_TRUE) begin
      res.hit = 1'b1;
    end else if (rule.dwell == 32'd0) begin
      res.hit = cond;
    end else if (cond) begin
      if (start == 32'd0) begin
        res.start_we = 1'b1;
        res.start_next = now_ms;
        res.hit = 1'b0;
      end else begin
        res.hit = (elapsed >= rule.dwell);
      end
    end else begin
      res.start_we = 1'b1;
      res.start_next = 32'd0;
      res.hit = 1'b0;
    end
  end
endmodule

// ===== design/priority_rule_transition_engine.sv =====
`timescale 1ns / 1ps
// Priority rule transition engine. Store and load items are taken while idle
// and give no result. A tick walks the rules through a single rule-table
// read port and a single shared compare unit: first it looks for an
// executing rule among the first rule_count rules (at most RULES), then, if
// none, scans those rules again (a table read step and an evaluate step per
// rule). busy is high for the whole tick. A tick that causes an event raises
// out_valid for exactly one cycle with the result item; the receiver cannot
// stall it, so it must take the item in that cycle. rule_count is written
// through the cfg channel, whose ready is high only while busy and start
// are both low.
module priority_rule_transition_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  prte_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output prte_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [4:0]           cfg_data
);
  import prte_pkg::*;

  fsm_t state, state_next;

  logic [4:0]  rule_count;
  logic [2:0]  cur_state;
  logic signed [31:0] sensors [SENSORS];
  rule_t       rule_mem [RULES];
  rule_t       rule_rd;
  logic [31:0] dwell_start [RULES];
  logic [RULES-1:0] exec_flag;
  logic [2:0]  next_cmd [RULES];

  logic [4:0]  limit;
  logic [4:0]  idx;
  logic [31:0] now;
  logic        found;
  logic [RW-1:0] best;
  logic [7:0]  best_prio;
  logic        accept;
  eval_t       ev;
  logic [RW-1:0] cur;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy && !start;
  assign limit = (rule_count > 5'(RULES)) ? 5'(RULES) : rule_count;
  assign cur = idx[RW-1:0];

  prte_eval u_eval (
    .rule     (rule_rd),
    .reading  (({1'b0, rule_rd.sensor} < 4'(SENSORS)) ? sensors[rule_rd.sensor] : 32'sd0),
    .start    (dwell_start[cur]),
    .now_ms   (now),
    .cur_state(cur_state),
    .res      (ev)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_item.action == ACT_TICK && limit != 5'd0) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_flag[cur]) begin
          state_next = ST_IDLE;
        end else if (idx == limit - 5'd1) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_EVAL: begin
        if (idx == limit - 5'd1) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rule table: one write port (loads), one registered read port (scan).
  always_ff @(posedge clk) begin
    if (accept && in_item.action == ACT_LOAD) begin
      rule_mem[in_item.rule_index] <= '{
        prio: in_item.priority_req, mask: in_item.state_mask,
        sensor: in_item.sensor_index, op: in_item.compare_op,
        threshold: in_item.value, dwell: in_item.dwell_ms,
        target: in_item.target_state,
        ncmd: (in_item.command_count > 3'(CMDS)) ? 3'(CMDS) : in_item.command_count,
        codes: in_item.command_codes};
    end
    rule_rd <= rule_mem[(state == ST_IDLE) ? 4'd0 :
                        ((state == ST_EXEC || state == ST_EVAL) ? 4'(idx + 5'd1) : cur)];
  end

  // Output and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      cur_state <= '0;
      exec_flag <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SENSORS; i++) sensors[i] <= '0;
      for (int i = 0; i < RULES; i++) begin
        dwell_start[i] <= '0;
        next_cmd[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) rule_count <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          found <= 1'b0;
          best <= '0;
          best_prio <= '0;
          now <= in_item.now_ms;
          if (accept && in_item.action == ACT_STORE) begin
            sensors[in_item.sensor_index] <= in_item.value;
          end
          if (accept && in_item.action == ACT_LOAD) begin
            exec_flag[in_item.rule_index] <= 1'b0;
            next_cmd[in_item.rule_index] <= '0;
            dwell_start[in_item.rule_index] <= '0;
          end
        end
        ST_EXEC: begin
          if (exec_flag[cur]) begin
            out_valid <= 1'b1;
            out_item.rule_number <= cur;
            if (next_cmd[cur] < rule_rd.ncmd) begin
              next_cmd[cur] <= next_cmd[cur] + 3'd1;
              out_item.event_kind <= EV_CMD;
              out_item.command_slot <= next_cmd[cur][1:0];
              out_item.command_code <= rule_rd.codes[4*next_cmd[cur][1:0] +: 4];
              out_item.machine_state <= cur_state;
            end else begin
              exec_flag[cur] <= 1'b0;
              cur_state <= rule_rd.target;
              out_item.event_kind <= EV_DONE;
              out_item.command_slot <= '0;
              out_item.command_code <= '0;
              out_item.machine_state <= rule_rd.target;
            end
          end else if (idx == limit - 5'd1) begin
            idx <= '0;
          end else begin
            idx <= idx + 5'd1;
          end
        end
        ST_READ: ;
        ST_EVAL: begin
          if (ev.start_we && ({1'b0, rule_rd.sensor} < 4'(SENSORS))) begin
            dwell_start[cur] <= ev.start_next;
          end
          if (ev.hit && (!found || rule_rd.prio > best_prio)) begin
            found <= 1'b1;
            best <= cur;
            best_prio <= rule_rd.prio;
          end
          idx <= idx + 5'd1;
        end
        ST_EMIT: begin
          if (found) begin
            exec_flag[best] <= 1'b1;
            next_cmd[best] <= '0;
            out_valid <= 1'b1;
            out_item.event_kind <= EV_START;
            out_item.rule_number <= best;
            out_item.command_slot <= '0;
            out_item.command_code <= '0;
            out_item.machine_state <= cur_state;
          end
        end
        default: ;
      endcase
    end
  end

  // The scan length only changes while no tick is being walked.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !busy)
    else $error("configuration written while busy");
  // A result never appears while a tick is still being walked.
  a_out_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_IDLE))
    else $error("result shown while busy");
  // A start event marks its rule as executing.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.event_kind == EV_START) |-> exec_flag[out_item.rule_number])
    else $error("started rule not executing");
endmodule
